// ===== hdl/cdpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// cdpfc_pkg
// Shared constants, register indexes, error codes and types of the discovery
// frame checker.
// ----------------------------------------------------------------------------
package cdpfc_pkg;

  // Frame layout
  localparam int PRELUDE_BYTES   = 22;
  localparam int MAX_FRAME_BYTES = 2048;

  // Byte position counts up to MAX_FRAME_BYTES itself (saturation point)
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam int LOC_W = 11;

  localparam logic [POS_W-1:0] POS_VERSION   = POS_W'(PRELUDE_BYTES);
  localparam logic [POS_W-1:0] POS_TTL       = POS_W'(PRELUDE_BYTES + 1);
  localparam logic [POS_W-1:0] POS_TLV_START = POS_W'(PRELUDE_BYTES + 4);
  localparam logic [POS_W-1:0] POS_MAX       = POS_W'(MAX_FRAME_BYTES);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TTL_MIN          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_TLV_TYPE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHASSIS_TLV_TYPE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_TLV_TYPE    = 3'd5;

  // Verdict error codes
  localparam logic [3:0] ERR_OK         = 4'd0;
  localparam logic [3:0] ERR_SHORT      = 4'd1;
  localparam logic [3:0] ERR_VERSION    = 4'd2;
  localparam logic [3:0] ERR_TTL        = 4'd3;
  localparam logic [3:0] ERR_HDR_CUT    = 4'd4;
  localparam logic [3:0] ERR_LEN_UNDER  = 4'd5;
  localparam logic [3:0] ERR_OVERRUN    = 4'd6;
  localparam logic [3:0] ERR_FIRST_TYPE = 4'd7;
  localparam logic [3:0] ERR_TOO_LONG   = 4'd8;

  typedef struct packed {
    logic [7:0]  version_min;
    logic [7:0]  version_max;
    logic [7:0]  ttl_min;
    logic [15:0] first_tlv_type;
    logic [15:0] chassis_tlv_type;
    logic [15:0] port_tlv_type;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic             pend;
    logic [LOC_W-1:0] offset;
    logic [LOC_W-1:0] length;
  } loc_t;

  typedef struct packed {
    logic             frame_valid;
    logic [3:0]       error_code;
    logic [7:0]       version_seen;
    logic [7:0]       ttl_seen;
    logic             chassis_found;
    logic [LOC_W-1:0] chassis_offset;
    logic [LOC_W-1:0] chassis_length;
    logic             port_found;
    logic [LOC_W-1:0] port_offset;
    logic [LOC_W-1:0] port_length;
  } verdict_t;

endpackage

// ===== hdl/cdpfc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cdpfc_cfg_regs
// Configuration register file: limits and TLV types, written by index.
// ----------------------------------------------------------------------------
module cdpfc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [cdpfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cdpfc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cdpfc_pkg::cfg_t                    cfg
);

  cdpfc_pkg::cfg_t regs;

  // Decode the index and update one register
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.version_min      <= 8'd1;
      regs.version_max      <= 8'd4;
      regs.ttl_min          <= 8'd3;
      regs.first_tlv_type   <= 16'd1;
      regs.chassis_tlv_type <= 16'd1;
      regs.port_tlv_type    <= 16'd3;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cdpfc_pkg::REG_VERSION_MIN:      regs.version_min      <= cfg_data[7:0];
        cdpfc_pkg::REG_VERSION_MAX:      regs.version_max      <= cfg_data[7:0];
        cdpfc_pkg::REG_TTL_MIN:          regs.ttl_min          <= cfg_data[7:0];
        cdpfc_pkg::REG_FIRST_TLV_TYPE:   regs.first_tlv_type   <= cfg_data;
        cdpfc_pkg::REG_CHASSIS_TLV_TYPE: regs.chassis_tlv_type <= cfg_data;
        cdpfc_pkg::REG_PORT_TLV_TYPE:    regs.port_tlv_type    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== hdl/cdpfc_walker.sv =====
// ----------------------------------------------------------------------------
// cdpfc_walker
// Per-frame state and the single-cycle update for one word: header capture,
// TLV chain walk, locator records and the verdict on the final word.
// ----------------------------------------------------------------------------
module cdpfc_walker (
  input  logic                  clk,
  input  logic                  rst,
  input  cdpfc_pkg::cfg_t       cfg,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output cdpfc_pkg::verdict_t   verdict
);

  // Frame state
  logic [cdpfc_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]                  version_reg, version_reg_next;
  logic [7:0]                  ttl_reg, ttl_reg_next;
  logic [cdpfc_pkg::POS_W-1:0] next_tlv_start, next_tlv_start_next;
  logic [1:0]                  header_byte_index, header_byte_index_next;
  logic [15:0]                 tlv_type_reg, tlv_type_reg_next;
  logic [7:0]                  tlv_len_hi, tlv_len_hi_next;
  logic                        first_tlv_done, first_tlv_done_next;
  logic [3:0]                  sticky_error, sticky_error_next;
  cdpfc_pkg::loc_t             chassis_record, chassis_record_next;
  cdpfc_pkg::loc_t             port_record, port_record_next;

  logic [cdpfc_pkg::POS_W-1:0] pos_inc;
  logic [15:0]                 tlv_len;
  logic [16:0]                 tlv_end;
  logic [cdpfc_pkg::POS_W-1:0] val_pos;
  logic [cdpfc_pkg::LOC_W-1:0] val_off;
  logic [15:0]                 val_len_full;
  logic [3:0]                  code;

  assign pos_inc      = byte_position + cdpfc_pkg::POS_W'(1);
  assign tlv_len      = {tlv_len_hi, data_byte};
  assign tlv_end      = 17'(next_tlv_start) + 17'(tlv_len);
  assign val_pos      = next_tlv_start + cdpfc_pkg::POS_W'(4);
  assign val_off      = (val_pos > cdpfc_pkg::POS_W'(2047)) ? cdpfc_pkg::LOC_W'(2047)
                                                            : val_pos[cdpfc_pkg::LOC_W-1:0];
  assign val_len_full = tlv_len - 16'd4;

  // Advance the frame state by one word
  always_comb begin
    version_reg_next       = version_reg;
    ttl_reg_next           = ttl_reg;
    next_tlv_start_next    = next_tlv_start;
    header_byte_index_next = header_byte_index;
    tlv_type_reg_next      = tlv_type_reg;
    tlv_len_hi_next        = tlv_len_hi;
    first_tlv_done_next    = first_tlv_done;
    sticky_error_next      = sticky_error;
    chassis_record_next    = chassis_record;
    port_record_next       = port_record;

    if (byte_position >= cdpfc_pkg::POS_MAX) begin
      if (sticky_error_next == cdpfc_pkg::ERR_OK) sticky_error_next = cdpfc_pkg::ERR_TOO_LONG;
    end else begin
      // Capture and check the version and TTL bytes
      if (byte_position == cdpfc_pkg::POS_VERSION) begin
        version_reg_next = data_byte;
        if ((data_byte < cfg.version_min || data_byte > cfg.version_max) &&
            sticky_error_next == cdpfc_pkg::ERR_OK) begin
          sticky_error_next = cdpfc_pkg::ERR_VERSION;
        end
      end
      if (byte_position == cdpfc_pkg::POS_TTL) begin
        ttl_reg_next = data_byte;
        if (data_byte < cfg.ttl_min && sticky_error_next == cdpfc_pkg::ERR_OK) begin
          sticky_error_next = cdpfc_pkg::ERR_TTL;
        end
      end

      // Walk the TLV chain while no error is pending
      if (sticky_error_next == cdpfc_pkg::ERR_OK &&
          byte_position >= cdpfc_pkg::POS_TLV_START) begin
        if (header_byte_index == 2'd0 && byte_position != next_tlv_start) begin
          // Inside a value: close pending records on its last byte
          if (pos_inc == next_tlv_start) begin
            if (chassis_record_next.pend) begin
              chassis_record_next.pend  = 1'b0;
              chassis_record_next.found = 1'b1;
            end
            if (port_record_next.pend) begin
              port_record_next.pend  = 1'b0;
              port_record_next.found = 1'b1;
            end
          end
        end else begin
          header_byte_index_next = header_byte_index + 2'd1;
          case (header_byte_index)
            2'd0: tlv_type_reg_next = {data_byte, 8'd0};
            2'd1: tlv_type_reg_next = {tlv_type_reg[15:8], data_byte};
            2'd2: tlv_len_hi_next   = data_byte;
            default: begin
              // Header complete: check it and step to the next TLV
              if (tlv_len < 16'd4) begin
                sticky_error_next = cdpfc_pkg::ERR_LEN_UNDER;
              end else if (!first_tlv_done && tlv_type_reg != cfg.first_tlv_type) begin
                sticky_error_next = cdpfc_pkg::ERR_FIRST_TYPE;
              end else if (tlv_end > 17'(cdpfc_pkg::MAX_FRAME_BYTES)) begin
                sticky_error_next = cdpfc_pkg::ERR_OVERRUN;
              end else begin
                first_tlv_done_next = 1'b1;
                next_tlv_start_next = tlv_end[cdpfc_pkg::POS_W-1:0];
                if (tlv_type_reg == cfg.chassis_tlv_type && !chassis_record.found) begin
                  chassis_record_next.pend   = 1'b1;
                  chassis_record_next.offset = val_off;
                  chassis_record_next.length = val_len_full[cdpfc_pkg::LOC_W-1:0];
                end
                if (tlv_type_reg == cfg.port_tlv_type && !port_record.found) begin
                  port_record_next.pend   = 1'b1;
                  port_record_next.offset = val_off;
                  port_record_next.length = val_len_full[cdpfc_pkg::LOC_W-1:0];
                end
                // Header-only TLV ends on this byte
                if (pos_inc == next_tlv_start_next) begin
                  if (chassis_record_next.pend) begin
                    chassis_record_next.pend  = 1'b0;
                    chassis_record_next.found = 1'b1;
                  end
                  if (port_record_next.pend) begin
                    port_record_next.pend  = 1'b0;
                    port_record_next.found = 1'b1;
                  end
                end
              end
            end
          endcase
        end
      end
    end

    byte_position_next = (byte_position < cdpfc_pkg::POS_MAX) ? pos_inc : byte_position;
  end

  // Final checks for the verdict
  always_comb begin
    code = sticky_error_next;
    if (code == cdpfc_pkg::ERR_OK) begin
      if (pos_inc <= cdpfc_pkg::POS_TLV_START) begin
        code = cdpfc_pkg::ERR_SHORT;
      end else if (header_byte_index_next != 2'd0) begin
        code = cdpfc_pkg::ERR_HDR_CUT;
      end else if (pos_inc < next_tlv_start_next) begin
        code = cdpfc_pkg::ERR_OVERRUN;
      end
    end

    verdict.frame_valid    = (code == cdpfc_pkg::ERR_OK);
    verdict.error_code     = code;
    verdict.version_seen   = version_reg_next;
    verdict.ttl_seen       = ttl_reg_next;
    verdict.chassis_found  = chassis_record_next.found;
    verdict.chassis_offset = chassis_record_next.found ? chassis_record_next.offset : '0;
    verdict.chassis_length = chassis_record_next.found ? chassis_record_next.length : '0;
    verdict.port_found     = port_record_next.found;
    verdict.port_offset    = port_record_next.found ? port_record_next.offset : '0;
    verdict.port_length    = port_record_next.found ? port_record_next.length : '0;
  end

  // Hold state, advance on each word, clear after the final word
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_position     <= '0;
      version_reg       <= '0;
      ttl_reg           <= '0;
      next_tlv_start    <= cdpfc_pkg::POS_TLV_START;
      header_byte_index <= '0;
      tlv_type_reg      <= '0;
      tlv_len_hi        <= '0;
      first_tlv_done    <= 1'b0;
      sticky_error      <= cdpfc_pkg::ERR_OK;
      chassis_record    <= '0;
      port_record       <= '0;
    end else if (step) begin
      byte_position     <= byte_position_next;
      version_reg       <= version_reg_next;
      ttl_reg           <= ttl_reg_next;
      next_tlv_start    <= next_tlv_start_next;
      header_byte_index <= header_byte_index_next;
      tlv_type_reg      <= tlv_type_reg_next;
      tlv_len_hi        <= tlv_len_hi_next;
      first_tlv_done    <= first_tlv_done_next;
      sticky_error      <= sticky_error_next;
      chassis_record    <= chassis_record_next;
      port_record       <= port_record_next;
    end
  end

endmodule

// ===== hdl/cdp_tlv_frame_checker.sv =====
// ----------------------------------------------------------------------------
// cdp_tlv_frame_checker
// Streaming structure check of a discovery frame, one word per cycle.
// Verdict path: the last word is held in the input register, then the walker
//   update is loaded into the verdict register.
// Throughput: one word per cycle; input stalls only while a finished verdict
//   waits and the next frame's last word needs the verdict register.
// Reset: rst clears all frame state and loads register defaults.
// ----------------------------------------------------------------------------
module cdp_tlv_frame_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration
  input  logic                                 cfg_wr_en,
  input  logic [cdpfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cdpfc_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Frame words
  input  logic                                 byte_valid,
  output logic                                 byte_stall,
  input  logic [7:0]                           data_byte,
  input  logic                                 last_byte,
  // Verdicts
  output logic                                 verdict_valid,
  input  logic                                 verdict_stall,
  output logic                                 frame_valid,
  output logic [3:0]                           error_code,
  output logic [7:0]                           version_seen,
  output logic [7:0]                           ttl_seen,
  output logic                                 chassis_found,
  output logic [cdpfc_pkg::LOC_W-1:0]          chassis_offset,
  output logic [cdpfc_pkg::LOC_W-1:0]          chassis_length,
  output logic                                 port_found,
  output logic [cdpfc_pkg::LOC_W-1:0]          port_offset,
  output logic [cdpfc_pkg::LOC_W-1:0]          port_length
);

  cdpfc_pkg::cfg_t     cfg;
  cdpfc_pkg::verdict_t verdict_comb;
  cdpfc_pkg::verdict_t verdict_reg;

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_free;
  logic       step;

  // A word steps when its verdict, if any, has room
  assign out_free   = !verdict_valid || !verdict_stall;
  assign step       = in_full && (!in_last || out_free);
  assign byte_stall = in_full && !step;

  cdpfc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte <= data_byte;
      in_last <= last_byte;
    end
  end

  cdpfc_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .data_byte (in_byte),
    .last_byte (in_last),
    .verdict   (verdict_comb)
  );

  // Verdict register: load on the final word, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (step && in_last) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      verdict_reg <= verdict_comb;
    end
  end

  assign frame_valid    = verdict_reg.frame_valid;
  assign error_code     = verdict_reg.error_code;
  assign version_seen   = verdict_reg.version_seen;
  assign ttl_seen       = verdict_reg.ttl_seen;
  assign chassis_found  = verdict_reg.chassis_found;
  assign chassis_offset = verdict_reg.chassis_offset;
  assign chassis_length = verdict_reg.chassis_length;
  assign port_found     = verdict_reg.port_found;
  assign port_offset    = verdict_reg.port_offset;
  assign port_length    = verdict_reg.port_length;

endmodule

// ===== dv/frame_verdict_sb_pkg.sv =====
// ----------------------------------------------------------------------------
// frame_verdict_sb_pkg
// Verdict predictor and scoreboard for the discovery frame checker. Every
// accepted frame word is run through a software copy of the checker; the
// verdict it produces on the last word is queued and compared field by field
// with the next verdict the block hands out.
// ----------------------------------------------------------------------------
package frame_verdict_sb_pkg;
  import cdpfc_pkg::*;

  class frame_verdict_sb;
    cfg_t        regs;
    logic [11:0] pos;
    logic [7:0]  version_q;
    logic [7:0]  ttl_q;
    logic [11:0] chain_end;
    logic [1:0]  hdr_idx;
    logic [15:0] tlv_type;
    logic [15:0] tlv_len;
    bit          first_done;
    logic [3:0]  first_err;
    loc_t        chassis_loc;
    loc_t        port_loc;
    verdict_t    verdicts_due[$];
    int unsigned verdicts_seen;
    int unsigned fail_count;

    function new();
      regs.version_min      = 8'd1;
      regs.version_max      = 8'd4;
      regs.ttl_min          = 8'd3;
      regs.first_tlv_type   = 16'd1;
      regs.chassis_tlv_type = 16'd1;
      regs.port_tlv_type    = 16'd3;
      verdicts_seen = 0;
      fail_count    = 0;
      clear_frame();
    endfunction

    // Return all per-frame state to its idle values; registers are kept
    function void clear_frame();
      pos         = '0;
      version_q   = '0;
      ttl_q       = '0;
      chain_end   = 12'(PRELUDE_BYTES + 4);
      hdr_idx     = '0;
      tlv_type    = '0;
      tlv_len     = '0;
      first_done  = 1'b0;
      first_err   = ERR_OK;
      chassis_loc = '0;
      port_loc    = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_VERSION_MIN:      regs.version_min      = data[7:0];
        REG_VERSION_MAX:      regs.version_max      = data[7:0];
        REG_TTL_MIN:          regs.ttl_min          = data[7:0];
        REG_FIRST_TLV_TYPE:   regs.first_tlv_type   = data;
        REG_CHASSIS_TLV_TYPE: regs.chassis_tlv_type = data;
        REG_PORT_TLV_TYPE:    regs.port_tlv_type    = data;
        default: ;
      endcase
    endfunction

    // Keep only the first error of a frame
    function void flag(logic [3:0] code);
      if (first_err == ERR_OK)
        first_err = code;
    endfunction

    // A located TLV counts once its last word has arrived
    function void settle_locs();
      if (chassis_loc.pend) begin
        chassis_loc.pend  = 1'b0;
        chassis_loc.found = 1'b1;
      end
      if (port_loc.pend) begin
        port_loc.pend  = 1'b0;
        port_loc.found = 1'b1;
      end
    endfunction

    function loc_t claim(loc_t r, int unsigned start, int unsigned len);
      int unsigned off;
      loc_t        n;
      n   = r;
      off = start + 4;
      if (r.found)
        return r;
      n.pend   = 1'b1;
      n.offset = (off > 2047) ? 11'd2047 : 11'(off);
      n.length = 11'(len - 4);
      return n;
    endfunction

    // Check a completed TLV header and advance the chain
    function void close_header(int unsigned p);
      int unsigned start;
      int unsigned len;
      start = chain_end;
      len   = tlv_len;
      if (len < 4) begin
        flag(ERR_LEN_UNDER);
        return;
      end
      if (!first_done && tlv_type != regs.first_tlv_type) begin
        flag(ERR_FIRST_TYPE);
        return;
      end
      if (start + len > MAX_FRAME_BYTES) begin
        flag(ERR_OVERRUN);
        return;
      end
      first_done = 1'b1;
      chain_end  = 12'(start + len);
      if (tlv_type == regs.chassis_tlv_type)
        chassis_loc = claim(chassis_loc, start, len);
      if (tlv_type == regs.port_tlv_type)
        port_loc = claim(port_loc, start, len);
      if (p + 1 == start + len)
        settle_locs();
    endfunction

    function void walk_chain(logic [7:0] b, int unsigned p);
      if (hdr_idx == 2'd0 && p != chain_end) begin
        if (p + 1 == chain_end)
          settle_locs();
        return;
      end
      case (hdr_idx)
        2'd0:    tlv_type = {b, 8'h00};
        2'd1:    tlv_type[7:0] = b;
        2'd2:    tlv_len = {b, 8'h00};
        default: tlv_len[7:0] = b;
      endcase
      hdr_idx = hdr_idx + 2'd1;
      if (hdr_idx == 2'd0)
        close_header(p);
    endfunction

    // Advance the frame by one accepted word; queue a verdict on the last one
    function void note_word(logic [7:0] b, logic last);
      int unsigned p;
      logic [3:0]  code;
      verdict_t    v;
      p = pos;
      if (p >= MAX_FRAME_BYTES) begin
        flag(ERR_TOO_LONG);
      end else begin
        if (p == PRELUDE_BYTES) begin
          version_q = b;
          if (b < regs.version_min || b > regs.version_max)
            flag(ERR_VERSION);
        end
        if (p == PRELUDE_BYTES + 1) begin
          ttl_q = b;
          if (b < regs.ttl_min)
            flag(ERR_TTL);
        end
        if (first_err == ERR_OK && p >= PRELUDE_BYTES + 4)
          walk_chain(b, p);
      end
      if (!last) begin
        if (pos < MAX_FRAME_BYTES)
          pos = pos + 12'd1;
        return;
      end
      code = first_err;
      if (code == ERR_OK) begin
        if (p + 1 <= PRELUDE_BYTES + 4)
          code = ERR_SHORT;
        else if (hdr_idx != 2'd0)
          code = ERR_HDR_CUT;
        else if (p + 1 < chain_end)
          code = ERR_OVERRUN;
      end
      v.frame_valid    = (code == ERR_OK);
      v.error_code     = code;
      v.version_seen   = version_q;
      v.ttl_seen       = ttl_q;
      v.chassis_found  = chassis_loc.found;
      v.chassis_offset = chassis_loc.found ? chassis_loc.offset : '0;
      v.chassis_length = chassis_loc.found ? chassis_loc.length : '0;
      v.port_found     = port_loc.found;
      v.port_offset    = port_loc.found ? port_loc.offset : '0;
      v.port_length    = port_loc.found ? port_loc.length : '0;
      verdicts_due.push_back(v);
      clear_frame();
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      $display("%0t verdict %0d: %s", $time, verdicts_seen, msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Compare one accepted verdict with the oldest expectation
    task check_verdict(verdict_t got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        report_mismatch("verdict with no frame outstanding");
        verdicts_seen++;
        return;
      end
      want = verdicts_due.pop_front();
      compare_field("frame_valid", 16'(got.frame_valid), 16'(want.frame_valid));
      compare_field("error_code", 16'(got.error_code), 16'(want.error_code));
      compare_field("version_seen", 16'(got.version_seen), 16'(want.version_seen));
      compare_field("ttl_seen", 16'(got.ttl_seen), 16'(want.ttl_seen));
      compare_field("chassis_found", 16'(got.chassis_found), 16'(want.chassis_found));
      compare_field("chassis_offset", 16'(got.chassis_offset), 16'(want.chassis_offset));
      compare_field("chassis_length", 16'(got.chassis_length), 16'(want.chassis_length));
      compare_field("port_found", 16'(got.port_found), 16'(want.port_found));
      compare_field("port_offset", 16'(got.port_offset), 16'(want.port_offset));
      compare_field("port_length", 16'(got.port_length), 16'(want.port_length));
      verdicts_seen++;
    endtask
  endclass

endpackage

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the discovery frame checker. Directed frames hit each verdict
// code below the frame size limit; random phases then send mostly well-formed
// TLV chains with random content and flaws under several register settings,
// with bursts of idling on both sides and one long verdict hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cdpfc_pkg::*;
  import frame_verdict_sb_pkg::*;

  localparam int HOLD_CYCLES   = 800;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 5000;
  localparam int TLV_BASE      = PRELUDE_BYTES + 4;

  typedef enum {
    FLAW_NONE, FLAW_CUT, FLAW_VERSION, FLAW_TTL, FLAW_SHORT_LEN,
    FLAW_FIRST_TYPE, FLAW_HUGE_LEN, FLAW_TAIL, FLAW_EMPTY, FLAW_NOISE
  } flaw_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  byte_valid;
  logic                  byte_stall;
  logic [7:0]            data_byte;
  logic                  last_byte;
  logic                  verdict_valid;
  logic                  verdict_stall;
  logic                  frame_valid;
  logic [3:0]            error_code;
  logic [7:0]            version_seen;
  logic [7:0]            ttl_seen;
  logic                  chassis_found;
  logic [LOC_W-1:0]      chassis_offset;
  logic [LOC_W-1:0]      chassis_length;
  logic                  port_found;
  logic [LOC_W-1:0]      port_offset;
  logic [LOC_W-1:0]      port_length;
  verdict_t              seen_verdict;

  frame_verdict_sb sb;
  logic [7:0]      frame_q[$];
  int unsigned     tlv_at[$];
  bit              hold_req   = 1'b0;
  int unsigned     gap_pct    = 0;
  int unsigned     stall_pct  = 0;
  int unsigned     words_sent = 0;

  cdp_tlv_frame_checker dut (.*);

  assign seen_verdict = {frame_valid, error_code, version_seen, ttl_seen,
                         chassis_found, chassis_offset, chassis_length,
                         port_found, port_offset, port_length};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Check every verdict that leaves the block
  always @(posedge clk) begin
    if (!rst && verdict_valid && !verdict_stall)
      sb.check_verdict(seen_verdict);
  end

  // Stall verdicts in random bursts, or for one long hold-off on request
  initial begin
    bit hold_done;
    hold_done     = 1'b0;
    verdict_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        verdict_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        verdict_stall = 1'b0;
        hold_done = 1'b1;
      end else if ($urandom_range(99) < stall_pct) begin
        verdict_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        verdict_stall = 1'b0;
      end
    end
  end

  // End the run when neither channel moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (byte_valid && !byte_stall) || (verdict_valid && !verdict_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one word, hold it until accepted, then note it
  task automatic put_word(logic [7:0] b, logic last);
    if ($urandom_range(99) < gap_pct) begin
      byte_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    byte_valid = 1'b1;
    data_byte  = b;
    last_byte  = last;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sb.note_word(b, last);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++)
      put_word(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Wait until every verdict is in, then let the pipeline settle
  task automatic drain();
    byte_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Write all six registers; the narrow ones get junk in the unused bits
  task automatic load_regs(logic [7:0] vmin, logic [7:0] vmax, logic [7:0] tmin,
                           logic [15:0] first, logic [15:0] chassis,
                           logic [15:0] port);
    set_reg(REG_VERSION_MIN, {8'($urandom), vmin});
    set_reg(REG_VERSION_MAX, {8'($urandom), vmax});
    set_reg(REG_TTL_MIN, {8'($urandom), tmin});
    set_reg(REG_FIRST_TLV_TYPE, first);
    set_reg(REG_CHASSIS_TLV_TYPE, chassis);
    set_reg(REG_PORT_TLV_TYPE, port);
  endtask

  task automatic random_regs();
    logic [7:0]  vmin;
    logic [15:0] first;
    logic [15:0] chassis;
    logic [15:0] port;
    vmin    = 8'($urandom_range(0, 120));
    first   = 16'($urandom);
    chassis = ($urandom_range(3) == 0) ? first : 16'($urandom);
    port    = ($urandom_range(3) == 0) ? chassis : 16'($urandom);
    load_regs(vmin, 8'($urandom_range(255, vmin)), 8'($urandom_range(0, 200)),
              first, chassis, port);
  endtask

  // Prelude, version, TTL and checksum
  function automatic void start_frame(logic [7:0] ver, logic [7:0] ttl);
    frame_q.delete();
    tlv_at.delete();
    repeat (PRELUDE_BYTES) frame_q.push_back(8'($urandom));
    frame_q.push_back(ver);
    frame_q.push_back(ttl);
    repeat (2) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void add_tlv(logic [15:0] typ, int unsigned vlen);
    logic [15:0] len;
    len = 16'(vlen + 4);
    tlv_at.push_back(frame_q.size());
    frame_q.push_back(typ[15:8]);
    frame_q.push_back(typ[7:0]);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
    repeat (vlen) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void set_len(int unsigned k, logic [15:0] len);
    frame_q[tlv_at[k] + 2] = len[15:8];
    frame_q[tlv_at[k] + 3] = len[7:0];
  endfunction

  function automatic logic [15:0] pick_type();
    case ($urandom_range(3))
      0:       return sb.regs.chassis_tlv_type;
      1:       return sb.regs.port_tlv_type;
      2:       return sb.regs.first_tlv_type;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void build_good();
    logic [7:0] ver;
    int unsigned n;
    if (sb.regs.version_min <= sb.regs.version_max)
      ver = 8'($urandom_range(sb.regs.version_max, sb.regs.version_min));
    else
      ver = 8'($urandom);
    start_frame(ver, 8'($urandom_range(255, sb.regs.ttl_min)));
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      add_tlv(i == 0 ? sb.regs.first_tlv_type : pick_type(),
              ($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12));
  endfunction

  function automatic flaw_t pick_flaw();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return FLAW_NONE;
    if (r < 58) return FLAW_CUT;
    if (r < 63) return FLAW_VERSION;
    if (r < 68) return FLAW_TTL;
    if (r < 74) return FLAW_SHORT_LEN;
    if (r < 79) return FLAW_FIRST_TYPE;
    if (r < 84) return FLAW_HUGE_LEN;
    if (r < 90) return FLAW_TAIL;
    if (r < 95) return FLAW_EMPTY;
    return FLAW_NOISE;
  endfunction

  // Well-formed chain, then at most one flaw on top
  function automatic void build_random_frame();
    int unsigned k;
    int unsigned keep;
    logic [15:0] ft;
    build_good();
    k = $urandom_range(tlv_at.size() - 1);
    case (pick_flaw())
      FLAW_CUT: begin
        keep = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end
      FLAW_VERSION: begin
        if (sb.regs.version_min > 0)
          frame_q[PRELUDE_BYTES] = 8'($urandom_range(0, sb.regs.version_min - 1));
        else if (sb.regs.version_max < 255)
          frame_q[PRELUDE_BYTES] = 8'($urandom_range(sb.regs.version_max + 1, 255));
      end
      FLAW_TTL: begin
        if (sb.regs.ttl_min > 0)
          frame_q[PRELUDE_BYTES + 1] = 8'($urandom_range(0, sb.regs.ttl_min - 1));
      end
      FLAW_SHORT_LEN: set_len(k, 16'($urandom_range(0, 3)));
      FLAW_FIRST_TYPE: begin
        ft = sb.regs.first_tlv_type ^ 16'($urandom_range(1, 65535));
        frame_q[TLV_BASE]     = ft[15:8];
        frame_q[TLV_BASE + 1] = ft[7:0];
      end
      FLAW_HUGE_LEN: set_len(k, 16'($urandom_range(65535, 2049 - tlv_at[k])));
      FLAW_TAIL: repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
      FLAW_EMPTY: begin
        keep = $urandom_range(1, TLV_BASE);
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end
      FLAW_NOISE: begin
        frame_q.delete();
        repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
      end
      default: ;
    endcase
  endfunction

  // Directed frames under the reset register values
  task automatic run_directed();
    // single word frame, then a bare header with an empty chain
    frame_q.delete();
    frame_q.push_back(8'($urandom));
    send_frame();
    start_frame(8'd2, 8'd5);
    send_frame();
    // valid chain with chassis, port and an unknown type
    start_frame(8'd1, 8'd3);
    add_tlv(16'd1, 5);
    add_tlv(16'd3, 0);
    add_tlv(16'hFFFF, 2);
    send_frame();
    // version below and above range, the latter with a bad TTL too
    start_frame(8'd0, 8'd255);
    add_tlv(16'd1, 1);
    send_frame();
    start_frame(8'd255, 8'd0);
    add_tlv(16'd1, 1);
    send_frame();
    // TTL under its limit
    start_frame(8'd4, 8'd2);
    add_tlv(16'd1, 1);
    send_frame();
    // frame ends inside a TLV header
    start_frame(8'd4, 8'd3);
    repeat (3) frame_q.push_back(8'h00);
    send_frame();
    // length under four on the first TLV, and on a later one after a chassis
    start_frame(8'd1, 8'd3);
    add_tlv(16'd1, 0);
    set_len(0, 16'd3);
    send_frame();
    start_frame(8'd1, 8'd3);
    add_tlv(16'd1, 2);
    add_tlv(16'd3, 0);
    set_len(1, 16'd0);
    send_frame();
    // wrong type on the first TLV
    start_frame(8'd3, 8'd3);
    add_tlv(16'd2, 3);
    send_frame();
    // frame ends before the TLV does
    start_frame(8'd1, 8'd3);
    add_tlv(16'd1, 10);
    repeat (3) void'(frame_q.pop_back());
    send_frame();
    // TLV reaching past the largest frame
    start_frame(8'd1, 8'd3);
    add_tlv(16'd1, 0);
    set_len(0, 16'hFFFF);
    send_frame();
    drain();
  endtask

  function automatic int unsigned pick_pct();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 4;
      2:       return 12;
      default: return 30;
    endcase
  endfunction

  task automatic run_phase(int unsigned budget, int unsigned gap, int unsigned stall);
    int unsigned first_word;
    gap_pct    = gap;
    stall_pct  = stall;
    first_word = words_sent;
    while (words_sent - first_word < budget) begin
      build_random_frame();
      send_frame();
    end
    drain();
  endtask

  initial begin
    rst        = 1'b1;
    cfg_wr_en  = 1'b0;
    cfg_index  = REG_VERSION_MIN;
    cfg_data   = '0;
    byte_valid = 1'b0;
    data_byte  = '0;
    last_byte  = 1'b0;
    sb = new();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    gap_pct   = 10;
    stall_pct = 10;
    run_directed();

    // everything accepted, matching locator types; verdicts held back at first
    // while words keep coming so the block fills up
    load_regs(8'd0, 8'd255, 8'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    hold_req = 1'b1;
    run_phase(180, 0, pick_pct());

    // only the top version and TTL pass
    load_regs(8'd255, 8'd255, 8'd255, 16'hFFFF, 16'd0, 16'hFFFF);
    run_phase(180, pick_pct(), pick_pct());

    // empty version range
    load_regs(8'd200, 8'd10, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(80, pick_pct(), pick_pct());

    repeat (2) begin
      random_regs();
      run_phase(200, pick_pct(), pick_pct());
    end

    // closing stretch at full rate
    random_regs();
    run_phase(220, 0, 0);

    if (sb.fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== cdp_tlv_frame_checker.f =====
hdl/cdpfc_pkg.sv
hdl/cdpfc_cfg_regs.sv
hdl/cdpfc_walker.sv
hdl/cdp_tlv_frame_checker.sv
dv/frame_verdict_sb_pkg.sv
dv/tb_top.sv
